// ----- src/u8xf_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 XML character filter package
// Shared types, constants and the XML character range check.
// ----------------------------------------------------------------------------
package u8xf_pkg;

  // Depth of the group queue between the decoder and the serialiser.
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = $clog2(QDepth + 1);

  // Expected sequence lengths held by the decoder.
  localparam logic [2:0] SEQ_NONE  = 3'd0;
  localparam logic [2:0] SEQ_TWO   = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR  = 3'd4;

  // Code point bounds of the XML character set and the overlong limits.
  localparam logic [20:0] CP_TAB       = 21'h00_0009;
  localparam logic [20:0] CP_LF        = 21'h00_000a;
  localparam logic [20:0] CP_CR        = 21'h00_000d;
  localparam logic [20:0] CP_BMP_LO    = 21'h00_0020;
  localparam logic [20:0] CP_BMP_HI    = 21'h00_d7ff;
  localparam logic [20:0] CP_PRIV_LO   = 21'h00_e000;
  localparam logic [20:0] CP_PRIV_HI   = 21'h00_fffd;
  localparam logic [20:0] CP_SUPP_LO   = 21'h01_0000;
  localparam logic [20:0] CP_SUPP_HI   = 21'h10_ffff;
  localparam logic [20:0] CP_MIN_THREE = 21'h00_0800;

  // Everything one request produces: up to four kept bytes and an end item.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            eos;
    logic            clean;
  } u8xf_grp_t;

  function automatic logic xml_char_ok(input logic [20:0] c);
    return (c >= CP_BMP_LO && c <= CP_BMP_HI) || c == CP_TAB || c == CP_LF ||
           c == CP_CR || (c >= CP_PRIV_LO && c <= CP_PRIV_HI) ||
           (c >= CP_SUPP_LO && c <= CP_SUPP_HI);
  endfunction

endpackage

// ----- src/u8xf_front.sv -----
// ----------------------------------------------------------------------------
// UTF-8 XML character filter decoder
// Accepts one byte per cycle while the queue is not full, tracks the pending sequence and emits a group.
// ----------------------------------------------------------------------------
module u8xf_front import u8xf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] byte_in,
  input  logic       final_in,
  input  logic       q_full,
  output logic       q_wr,
  output u8xf_grp_t  q_data
);

  logic [2:0]      exp_r, exp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [14:0]     part_r, part_nxt;
  logic [2:0][7:0] pb_r, pb_nxt;
  logic            drop_r, drop_nxt;

  logic            acc;
  logic            pend;
  logic            cont;
  logic            drop;
  logic            ok;
  logic [20:0]     cp;
  u8xf_grp_t       grp;

  assign acc  = push && !q_full;
  assign pend = (exp_r != SEQ_NONE);
  assign cont = (byte_in[7:6] == 2'b10);
  assign cp   = {part_r, byte_in[5:0]};

  always_comb begin
    exp_nxt   = exp_r;
    cnt_nxt   = cnt_r;
    part_nxt  = part_r;
    pb_nxt    = pb_r;
    drop      = 1'b0;
    ok        = 1'b0;
    grp       = '0;
    grp.bytes = {8'h00, pb_r[2], pb_r[1], pb_r[0]};

    if (pend && cont) begin
      if ({1'b0, cnt_r} + 3'd1 >= exp_r) begin
        ok = xml_char_ok(cp) && !(exp_r == SEQ_THREE && cp < CP_MIN_THREE) &&
             !(exp_r == SEQ_FOUR && cp < CP_SUPP_LO);
        if (ok) begin
          grp.bytes[cnt_r] = byte_in;
          grp.nbytes       = {1'b0, cnt_r} + 3'd1;
        end else begin
          drop = 1'b1;
        end
        exp_nxt  = SEQ_NONE;
        cnt_nxt  = 2'd0;
        part_nxt = '0;
      end else begin
        pb_nxt[cnt_r] = byte_in;
        cnt_nxt       = cnt_r + 2'd1;
        part_nxt      = cp[14:0];
      end
    end else begin
      // A byte that breaks a pending sequence throws the held bytes away.
      if (pend) begin
        drop     = 1'b1;
        exp_nxt  = SEQ_NONE;
        cnt_nxt  = 2'd0;
        part_nxt = '0;
      end
      if (!byte_in[7]) begin
        if (xml_char_ok({13'd0, byte_in})) begin
          grp.bytes[0] = byte_in;
          grp.nbytes   = 3'd1;
        end else begin
          drop = 1'b1;
        end
      end else if (byte_in inside {[8'hc2:8'hdf]}) begin
        exp_nxt   = SEQ_TWO;
        part_nxt  = {10'd0, byte_in[4:0]};
        pb_nxt[0] = byte_in;
        cnt_nxt   = 2'd1;
      end else if (byte_in inside {[8'he0:8'hef]}) begin
        exp_nxt   = SEQ_THREE;
        part_nxt  = {11'd0, byte_in[3:0]};
        pb_nxt[0] = byte_in;
        cnt_nxt   = 2'd1;
      end else if (byte_in inside {[8'hf0:8'hf4]}) begin
        exp_nxt   = SEQ_FOUR;
        part_nxt  = {12'd0, byte_in[2:0]};
        pb_nxt[0] = byte_in;
        cnt_nxt   = 2'd1;
      end else begin
        drop = 1'b1;
      end
    end

    if (final_in) begin
      if (exp_nxt != SEQ_NONE) begin
        drop     = 1'b1;
        exp_nxt  = SEQ_NONE;
        cnt_nxt  = 2'd0;
        part_nxt = '0;
      end
      grp.eos   = 1'b1;
      grp.clean = !(drop_r || drop);
      drop_nxt  = 1'b0;
    end else begin
      drop_nxt = drop_r || drop;
    end
  end

  assign q_wr   = acc && (grp.nbytes != 3'd0 || grp.eos);
  assign q_data = grp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= SEQ_NONE;
      cnt_r  <= 2'd0;
      part_r <= '0;
      drop_r <= 1'b0;
    end else if (acc) begin
      exp_r  <= exp_nxt;
      cnt_r  <= cnt_nxt;
      part_r <= part_nxt;
      drop_r <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pb_r <= pb_nxt;
    end
  end

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && final_in |=> exp_r == SEQ_NONE && !drop_r)
    else $error("decoder state not cleared after the final byte");

  a_cnt_matches_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) == (exp_r == SEQ_NONE))
    else $error("pending count disagrees with the expected length");

endmodule

// ----- src/u8xf_queue.sv -----
// ----------------------------------------------------------------------------
// UTF-8 XML character filter group queue
// Short first-in first-out store of groups between decoder and serialiser.
// ----------------------------------------------------------------------------
module u8xf_queue import u8xf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr,
  input  u8xf_grp_t wr_data,
  output logic      full,
  input  logic      rd,
  output u8xf_grp_t rd_data,
  output logic      empty
);

  u8xf_grp_t        mem_r [QDepth];
  logic [QAw-1:0]   wp_r, rp_r;
  logic [QCw-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCw'(QDepth));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + QCw'(1);
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - QCw'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + QAw'(1);
      end
      if (rd) begin
        rp_r <= rp_r + QAw'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr && full && !rd) && !(rd && empty))
    else $error("queue written while full or read while empty");

endmodule

// ----- src/u8xf_back.sv -----
// ----------------------------------------------------------------------------
// UTF-8 XML character filter serialiser
// Unpacks each group into single results, one per cycle while pop is held.
// ----------------------------------------------------------------------------
module u8xf_back import u8xf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  u8xf_grp_t  q_data,
  output logic       q_rd,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_is_data,
  output logic       out_end_of_string,
  output logic       out_was_clean,
  output logic       out_last_of_run
);

  u8xf_grp_t  cur_r, cur_nxt;
  logic       vld_r, vld_nxt;
  logic [2:0] idx_r, idx_nxt;

  logic [2:0] total;
  logic       is_last;
  logic       is_byte;
  logic       take;
  logic       load;

  assign total   = cur_r.nbytes + {2'd0, cur_r.eos};
  assign is_last = (idx_r + 3'd1 == total);
  assign is_byte = (idx_r < cur_r.nbytes);
  assign take    = pop && vld_r;
  assign load    = !vld_r || (take && is_last);
  assign q_rd    = load && !q_empty;

  always_comb begin
    cur_nxt = cur_r;
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (load) begin
      cur_nxt = q_data;
      vld_nxt = !q_empty;
      idx_nxt = 3'd0;
    end else if (take) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 3'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign empty             = !vld_r;
  assign out_byte          = is_byte ? cur_r.bytes[idx_r[1:0]] : 8'h00;
  assign out_is_data       = is_byte;
  assign out_end_of_string = !is_byte;
  assign out_was_clean     = !is_byte && cur_r.clean;
  assign out_last_of_run   = is_last;

  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> idx_r < total)
    else $error("result index runs past the end of its group");

endmodule

// ----- src/utf8_xml_char_filter.sv -----
// ----------------------------------------------------------------------------
// UTF-8 XML character filter
// Streaming UTF-8 decoder that keeps only well-formed allowed XML characters.
// ----------------------------------------------------------------------------
// The block takes a string one nonzero byte per request and passes on, byte
// for byte, every complete UTF-8 sequence that encodes an allowed XML
// character; malformed, overlong, surrogate, out-of-range or disallowed
// sequences are dropped whole, and a request marked final is followed by an
// end item that says whether anything in the string was dropped. A request
// is taken on every cycle in which full is low, so the input runs at one
// byte per cycle. Results leave at one per cycle while pop is held; a
// request that completes a multi-byte character yields all of its bytes at
// once, so the output side, which serialises these groups, sets the
// sustained rate whenever the text is rich in long sequences or short
// strings. A four-entry group queue sits between the decoder and the
// serialiser, and full rises only when that queue is full. A byte passes
// through the group queue and the serialiser's group register on its way out.
// ----------------------------------------------------------------------------
module utf8_xml_char_filter import u8xf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel.
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_final_byte,
  // Result channel.
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_is_data,
  output logic       out_end_of_string,
  output logic       out_was_clean,
  output logic       out_last_of_run
);

  // Groups travel from the decoder through the queue to the serialiser.
  u8xf_grp_t wr_grp;
  u8xf_grp_t rd_grp;
  logic      q_wr;
  logic      q_rd;
  logic      q_full;
  logic      q_empty;

  // The decoder holds its state while the queue is full, so
  // the queue's full flag is also the back-pressure seen by the sender.
  assign full = q_full;

  u8xf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .byte_in  (in_byte),
    .final_in (in_final_byte),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_data   (wr_grp)
  );

  u8xf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (wr_grp),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (rd_grp),
    .empty   (q_empty)
  );

  // The serialiser loads the next group in the same cycle that the last
  // result of the current one is popped, so there is no bubble between them.
  u8xf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (rd_grp),
    .q_rd              (q_rd),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_is_data       (out_is_data),
    .out_end_of_string (out_end_of_string),
    .out_was_clean     (out_was_clean),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

// ----- verif/u8xf_filter_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 XML character filter checker
// Watches both channels, predicts the filtered stream and compares results.
// ----------------------------------------------------------------------------
module u8xf_filter_checker import u8xf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_final_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic       out_is_data,
  input  logic       out_end_of_string,
  input  logic       out_was_clean,
  input  logic       out_last_of_run,
  output int         fail_count,
  output int         results_owed
);

  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       eos;
    logic       clean;
    logic       last;
  } filt_res_t;

  // Filtered results still due from the block, oldest first.
  filt_res_t filt_q[$];

  // Decoder state of the prediction.
  logic [7:0]  held [3];
  int          held_cnt;
  logic [2:0]  seq_len;
  logic [20:0] cp_acc;
  logic        dirty;

  function automatic logic allowed_char(input logic [20:0] c);
    return c == CP_TAB || c == CP_LF || c == CP_CR ||
           (c >= CP_BMP_LO && c <= CP_BMP_HI) ||
           (c >= CP_PRIV_LO && c <= CP_PRIV_HI) ||
           (c >= CP_SUPP_LO && c <= CP_SUPP_HI);
  endfunction

  function automatic filt_res_t kept_byte(input logic [7:0] b);
    return '{data: b, is_data: 1'b1, eos: 1'b0, clean: 1'b0, last: 1'b0};
  endfunction

  task automatic clear_held();
    held[0]  = 8'h00;
    held[1]  = 8'h00;
    held[2]  = 8'h00;
    held_cnt = 0;
    seq_len  = SEQ_NONE;
    cp_acc   = '0;
  endtask

  // Works out the results of one accepted request and queues them.
  task automatic filter_byte(input logic [7:0] b, input logic fin);
    filt_res_t   run_q[$];
    logic [20:0] cp;
    logic        ok;
    if (seq_len != SEQ_NONE && b[7:6] == 2'b10) begin
      cp = {cp_acc[14:0], b[5:0]};
      if (held_cnt + 1 >= seq_len || held_cnt >= 3) begin
        ok = allowed_char(cp);
        // Overlong forms of three and four bytes.
        if (seq_len == SEQ_THREE && cp < CP_MIN_THREE) ok = 1'b0;
        if (seq_len == SEQ_FOUR && cp < CP_SUPP_LO) ok = 1'b0;
        if (ok) begin
          for (int i = 0; i < held_cnt; i++) run_q.push_back(kept_byte(held[i]));
          run_q.push_back(kept_byte(b));
        end else begin
          dirty = 1'b1;
        end
        clear_held();
      end else begin
        held[held_cnt] = b;
        held_cnt++;
        cp_acc = cp;
      end
    end else begin
      // A non-continuation byte breaks whatever sequence was pending.
      if (seq_len != SEQ_NONE) begin
        dirty = 1'b1;
        clear_held();
      end
      if (!b[7]) begin
        if (allowed_char({13'd0, b})) run_q.push_back(kept_byte(b));
        else dirty = 1'b1;
      end else if (b >= 8'hc2 && b <= 8'hdf) begin
        seq_len  = SEQ_TWO;
        cp_acc   = {16'd0, b[4:0]};
        held[0]  = b;
        held_cnt = 1;
      end else if (b >= 8'he0 && b <= 8'hef) begin
        seq_len  = SEQ_THREE;
        cp_acc   = {17'd0, b[3:0]};
        held[0]  = b;
        held_cnt = 1;
      end else if (b >= 8'hf0 && b <= 8'hf4) begin
        seq_len  = SEQ_FOUR;
        cp_acc   = {18'd0, b[2:0]};
        held[0]  = b;
        held_cnt = 1;
      end else begin
        dirty = 1'b1;
      end
    end
    if (fin) begin
      if (seq_len != SEQ_NONE) begin
        dirty = 1'b1;
        clear_held();
      end
      run_q.push_back('{data: 8'h00, is_data: 1'b0, eos: 1'b1, clean: !dirty,
                        last: 1'b0});
      dirty = 1'b0;
    end
    if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
    foreach (run_q[i]) filt_q.push_back(run_q[i]);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    filt_res_t want;
    if (!rst_n) begin
      clear_held();
      dirty      = 1'b0;
      fail_count = 0;
      filt_q.delete();
    end else begin
      if (pop && !empty) begin
        if (filt_q.size() == 0) begin
          $error("out_byte: expected no result, got %0h", out_byte);
          fail_count++;
        end else begin
          want = filt_q.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("out_is_data", {7'd0, want.is_data}, {7'd0, out_is_data});
          check_field("out_end_of_string", {7'd0, want.eos},
                      {7'd0, out_end_of_string});
          check_field("out_was_clean", {7'd0, want.clean}, {7'd0, out_was_clean});
          check_field("out_last_of_run", {7'd0, want.last},
                      {7'd0, out_last_of_run});
        end
      end
      if (push && !full) filter_byte(in_byte, in_final_byte);
    end
    results_owed = filt_q.size();
  end

endmodule

// ----- verif/tb_utf8_xml_char_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 XML character filter testbench
// Drives strings of directed and random UTF-8 bytes under varying idling.
// ----------------------------------------------------------------------------
// A short directed part covers the allowed controls, invalid leads, a stray
// continuation, overlong and surrogate forms, the range limits, a broken
// sequence and a sequence cut short by the final byte. The random part then
// builds strings that are mostly well-formed characters, mixed with
// rejected code points, noise bytes and truncated sequences. The checker
// beside the block predicts and compares every result; this module only
// makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_utf8_xml_char_filter import u8xf_pkg::*;;

  // Number of random bytes to send after the directed part.
  localparam int RandomBytes = 350;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       push          = 1'b0;
  logic [7:0] in_byte       = 8'h41;
  logic       in_final_byte = 1'b0;
  logic       pop           = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_is_data;
  logic       out_end_of_string;
  logic       out_was_clean;
  logic       out_last_of_run;

  int fail_count;
  int results_owed;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int idle_pct   = 0;
  int stall_pct  = 0;
  int bytes_sent = 0;

  // The string being built, one byte per entry.
  logic [7:0] str_q[$];

  utf8_xml_char_filter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_byte           (in_byte),
    .in_final_byte     (in_final_byte),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_is_data       (out_is_data),
    .out_end_of_string (out_end_of_string),
    .out_was_clean     (out_was_clean),
    .out_last_of_run   (out_last_of_run)
  );

  u8xf_filter_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_byte           (in_byte),
    .in_final_byte     (in_final_byte),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_is_data       (out_is_data),
    .out_end_of_string (out_end_of_string),
    .out_was_clean     (out_was_clean),
    .out_last_of_run   (out_last_of_run),
    .fail_count        (fail_count),
    .results_owed      (results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, once per cycle, at the current rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Appends the UTF-8 form of a code point at the given length. The lead
  // simply takes the top bits, so short code points give overlong forms.
  task automatic put_char(input logic [20:0] cp, input int len);
    case (len)
      1: str_q.push_back(cp[7:0]);
      2: begin
        str_q.push_back({3'b110, cp[10:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        str_q.push_back({4'b1110, cp[15:12]});
        str_q.push_back({2'b10, cp[11:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        str_q.push_back({5'b11110, cp[20:18]});
        str_q.push_back({2'b10, cp[17:12]});
        str_q.push_back({2'b10, cp[11:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Builds a random string: mostly allowed characters of every length, the
  // rest rejected code points, noise bytes and sequences cut short.
  task automatic build_string();
    int          n_chars;
    int          kind;
    int          len;
    logic [20:0] cp;
    str_q.delete();
    n_chars = $urandom_range(1, 6);
    repeat (n_chars) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        len = $urandom_range(1, 4);
        case (len)
          1: begin
            if ($urandom_range(3) == 0) begin
              case ($urandom_range(2))
                0:       cp = CP_TAB;
                1:       cp = CP_LF;
                default: cp = CP_CR;
              endcase
            end else begin
              cp = 21'($urandom_range(32'h20, 32'h7f));
            end
          end
          2: cp = 21'($urandom_range(32'h80, 32'h7ff));
          3: begin
            if ($urandom_range(1) == 0) cp = 21'($urandom_range(32'h800, 32'hd7ff));
            else cp = 21'($urandom_range(32'he000, 32'hfffd));
          end
          default: cp = 21'($urandom_range(32'h10000, 32'h10ffff));
        endcase
        put_char(cp, len);
      end else if (kind < 75) begin
        // Well-formed in shape, mostly with a refused code point (a control may be tab, LF or CR).
        case ($urandom_range(5))
          0:       put_char(21'($urandom_range(32'hd800, 32'hdfff)), 3);
          1:       put_char(21'($urandom_range(32'hfffe, 32'hffff)), 3);
          2:       put_char(21'($urandom_range(32'h0, 32'h7ff)), 3);
          3:       put_char(21'($urandom_range(32'h0, 32'hffff)), 4);
          4:       put_char(21'($urandom_range(32'h110000, 32'h13ffff)), 4);
          default: put_char(21'($urandom_range(32'h1, 32'h1f)), 1);
        endcase
      end else if (kind < 90) begin
        str_q.push_back(8'($urandom_range(1, 255)));
      end else begin
        len = $urandom_range(3, 4);
        if (len == 3) cp = 21'($urandom_range(32'h800, 32'hd7ff));
        else cp = 21'($urandom_range(32'h10000, 32'h10ffff));
        put_char(cp, len);
        repeat ($urandom_range(1, len - 1)) void'(str_q.pop_back());
      end
    end
  endtask

  // Sends the string, one request per byte, marking the last as final.
  // Full is read at the falling edge, where it is settled, to know whether
  // the next rising edge takes the request.
  task automatic send_string();
    logic accepted;
    for (int i = 0; i < str_q.size(); i++) begin
      while ($urandom_range(99) < idle_pct) begin
        push <= 1'b0;
        @(posedge clk);
      end
      push          <= 1'b1;
      in_byte       <= str_q[i];
      in_final_byte <= (i == str_q.size() - 1);
      do begin
        @(negedge clk);
        accepted = !full;
        @(posedge clk);
      end while (!accepted);
      bytes_sent++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Tab, line feed and carriage return alone: a clean string.
    str_q = '{8'h09, 8'h0a, 8'h0d};
    send_string();
    // A disallowed control, invalid leads, a stray continuation and the
    // smallest two-byte character.
    str_q = '{8'h1f, 8'hc1, 8'hff, 8'h80, 8'hc2, 8'h80};
    send_string();
    // An overlong three-byte form, a surrogate, then the highest allowed
    // character of the basic plane.
    str_q = '{8'he0, 8'h80, 8'h80, 8'hed, 8'ha0, 8'h80, 8'hef, 8'hbf, 8'hbd};
    send_string();
    // The first code point past the range, then the last one inside it.
    str_q = '{8'hf4, 8'h90, 8'h80, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
    send_string();
    // A sequence broken by a plain byte, and one cut off by the final byte.
    str_q = '{8'he2, 8'h41, 8'hf0};
    send_string();

    // Random strings through four idling phases: none, sender idle,
    // receiver stalling, then both at a lighter rate.
    bytes_sent = 0;
    while (bytes_sent < RandomBytes) begin
      case (bytes_sent * 4 / RandomBytes)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 73;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 73;
        end
        default: begin
          idle_pct  = 17;
          stall_pct = 17;
        end
      endcase
      build_string();
      send_string();
    end
    push      <= 1'b0;
    stall_pct = 0;

    // Let the checker take the last request, drain, then watch for strays.
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
